### hw/rtl/nnfs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nnfs_pkg
// Shared types and constants of the nearest-neighbor frame scaler.
// ============================================================================
package nnfs_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y = 3'd5;

    // Field widths
    localparam int DIM_W   = 8;   // destination size, window offset, out coordinate
    localparam int SRC_W   = 9;   // source size
    localparam int SADDR_W = 15;  // store address port
    localparam int PIX_W   = 16;  // RGB565
    localparam int CLIP_W  = 11;  // window offset + size against screen size

    // Divider: (8-bit coordinate * 9-bit size) / 8-bit size
    localparam int NUM_W     = DIM_W + SRC_W;
    localparam int DEN_W     = DIM_W;
    localparam int QUO_W     = SRC_W;   // quotient always below the source size
    localparam int DIV_CNT_W = 5;

    // row * in_w + col stays below 511 * 511
    localparam int CALC_W = 2 * SRC_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FETCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLIP    = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // One classified item as it travels from front to back
    typedef struct packed {
        t_op                 op;
        logic [SADDR_W-1:0]  store_addr;
        logic [PIX_W-1:0]    pixel_in;
        logic [DIM_W-1:0]    out_x;
        logic [DIM_W-1:0]    out_y;
        logic [DIM_W-1:0]    screen_x;
        logic [DIM_W-1:0]    screen_y;
        t_status             status;
        logic                scaling;
        logic [NUM_W-1:0]    num_row;
        logic [NUM_W-1:0]    num_col;
        logic [DEN_W-1:0]    den_row;
        logic [DEN_W-1:0]    den_col;
        logic [SRC_W-1:0]    in_w;
    } t_job;

endpackage

### hw/rtl/nnfs_div.sv
`timescale 1ns / 1ps
// ============================================================================
// nnfs_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module nnfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nnfs_pkg::NUM_W-1:0]  i_num,
    input  logic [nnfs_pkg::DEN_W-1:0]  i_den,
    output logic                        o_busy,
    output logic [nnfs_pkg::NUM_W-1:0]  o_quo
);

    logic [nnfs_pkg::DEN_W-1:0]     r_rem;
    logic [nnfs_pkg::NUM_W-1:0]     r_quo;
    logic [nnfs_pkg::DEN_W-1:0]     r_den;
    logic [nnfs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;

    logic [nnfs_pkg::DEN_W:0]       trial;
    logic [nnfs_pkg::DEN_W:0]       diff;
    logic                           ge;

    assign trial = {r_rem, r_quo[nnfs_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= nnfs_pkg::DIV_CNT_W'(nnfs_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == nnfs_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder below divisor, so it fits the divisor width either way
            r_rem <= ge ? diff[nnfs_pkg::DEN_W-1:0] : trial[nnfs_pkg::DEN_W-1:0];
            r_quo <= {r_quo[nnfs_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/nnfs_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// nnfs_queue
// Short FIFO of classified jobs between front and back.
// ============================================================================
module nnfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nnfs_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output nnfs_pkg::t_job  o_job
);

    nnfs_pkg::t_job                r_slot [nnfs_pkg::QUEUE_DEPTH];
    logic [nnfs_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [nnfs_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [nnfs_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = r_count == nnfs_pkg::QCNT_W'(nnfs_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

### hw/rtl/nnfs_front.sv
`timescale 1ns / 1ps
// ============================================================================
// nnfs_front
// Configuration registers, input transfer and classification of each item.
// ============================================================================
module nnfs_front #(
    parameter int SCREEN_W = 240,
    parameter int SCREEN_H = 240
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nnfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nnfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_op,
    input  logic [nnfs_pkg::SADDR_W-1:0]     i_store_addr,
    input  logic [nnfs_pkg::PIX_W-1:0]       i_pixel_in,
    input  logic [nnfs_pkg::DIM_W-1:0]       i_out_x,
    input  logic [nnfs_pkg::DIM_W-1:0]       i_out_y,
    input  logic                             i_full,
    output logic                             o_push,
    output nnfs_pkg::t_job                   o_job
);

    localparam logic [nnfs_pkg::CLIP_W-1:0] ScreenW = nnfs_pkg::CLIP_W'(SCREEN_W);
    localparam logic [nnfs_pkg::CLIP_W-1:0] ScreenH = nnfs_pkg::CLIP_W'(SCREEN_H);

    logic [nnfs_pkg::DIM_W-1:0] r_dest_w;
    logic [nnfs_pkg::DIM_W-1:0] r_dest_h;
    logic [nnfs_pkg::SRC_W-1:0] r_src_w;
    logic [nnfs_pkg::SRC_W-1:0] r_src_h;
    logic [nnfs_pkg::DIM_W-1:0] r_win_x;
    logic [nnfs_pkg::DIM_W-1:0] r_win_y;

    logic [nnfs_pkg::SRC_W-1:0]  in_w;
    logic [nnfs_pkg::SRC_W-1:0]  in_h;
    logic                        scaling;
    logic [nnfs_pkg::CLIP_W-1:0] sum_x;
    logic [nnfs_pkg::CLIP_W-1:0] sum_y;
    logic [nnfs_pkg::CLIP_W-1:0] room_x;
    logic [nnfs_pkg::CLIP_W-1:0] room_y;
    logic                        over_x;
    logic                        over_y;
    logic                        pos_x;
    logic                        pos_y;
    logic [nnfs_pkg::DIM_W-1:0]  draw_w;
    logic [nnfs_pkg::DIM_W-1:0]  draw_h;
    logic                        bad_dim;
    logic                        outside;
    nnfs_pkg::t_status           status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w <= 8'd160;
            r_dest_h <= 8'd144;
            r_src_w  <= '0;
            r_src_h  <= '0;
            r_win_x  <= '0;
            r_win_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nnfs_pkg::CFG_DEST_W:   r_dest_w <= i_cfg_data[nnfs_pkg::DIM_W-1:0];
                nnfs_pkg::CFG_DEST_H:   r_dest_h <= i_cfg_data[nnfs_pkg::DIM_W-1:0];
                nnfs_pkg::CFG_SRC_W:    r_src_w  <= i_cfg_data;
                nnfs_pkg::CFG_SRC_H:    r_src_h  <= i_cfg_data;
                nnfs_pkg::CFG_WINDOW_X: r_win_x  <= i_cfg_data[nnfs_pkg::DIM_W-1:0];
                nnfs_pkg::CFG_WINDOW_Y: r_win_y  <= i_cfg_data[nnfs_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero source size means same as destination
    assign in_w    = (r_src_w != '0) ? r_src_w : {1'b0, r_dest_w};
    assign in_h    = (r_src_h != '0) ? r_src_h : {1'b0, r_dest_h};
    assign scaling = (in_w != {1'b0, r_dest_w}) || (in_h != {1'b0, r_dest_h});

    // Clip window to screen; a clipped size is below the requested one
    assign sum_x  = nnfs_pkg::CLIP_W'(r_win_x) + nnfs_pkg::CLIP_W'(r_dest_w);
    assign sum_y  = nnfs_pkg::CLIP_W'(r_win_y) + nnfs_pkg::CLIP_W'(r_dest_h);
    assign room_x = ScreenW - nnfs_pkg::CLIP_W'(r_win_x);
    assign room_y = ScreenH - nnfs_pkg::CLIP_W'(r_win_y);
    assign over_x = sum_x > ScreenW;
    assign over_y = sum_y > ScreenH;
    assign pos_x  = !over_x || (nnfs_pkg::CLIP_W'(r_win_x) < ScreenW);
    assign pos_y  = !over_y || (nnfs_pkg::CLIP_W'(r_win_y) < ScreenH);
    assign draw_w = over_x ? room_x[nnfs_pkg::DIM_W-1:0] : r_dest_w;
    assign draw_h = over_y ? room_y[nnfs_pkg::DIM_W-1:0] : r_dest_h;

    assign bad_dim = (r_dest_w == '0) || (r_dest_h == '0) || !pos_x || !pos_y;
    assign outside = (i_out_x >= draw_w) || (i_out_y >= draw_h);

    always_comb begin
        if (bad_dim) begin
            status = nnfs_pkg::ST_INVALID;
        end else if (outside) begin
            status = nnfs_pkg::ST_CLIP;
        end else begin
            status = nnfs_pkg::ST_OK;
        end
    end

    assign o_push = i_in_valid && !i_full;

    always_comb begin
        o_job            = '0;
        o_job.op         = nnfs_pkg::t_op'(i_op);
        o_job.store_addr = i_store_addr;
        o_job.pixel_in   = i_pixel_in;
        o_job.out_x      = i_out_x;
        o_job.out_y      = i_out_y;
        o_job.screen_x   = r_win_x + i_out_x;
        o_job.screen_y   = r_win_y + i_out_y;
        o_job.status     = status;
        o_job.scaling    = scaling;
        o_job.num_row    = nnfs_pkg::NUM_W'(i_out_y) * nnfs_pkg::NUM_W'(in_h);
        o_job.num_col    = nnfs_pkg::NUM_W'(i_out_x) * nnfs_pkg::NUM_W'(in_w);
        o_job.den_row    = r_dest_h;
        o_job.den_col    = draw_w;
        o_job.in_w       = in_w;
    end

endmodule

### hw/rtl/nnfs_back.sv
`timescale 1ns / 1ps
// ============================================================================
// nnfs_back
// Executes jobs: store writes, index division, address, store read, result.
// ============================================================================
module nnfs_back #(
    parameter int STORE_DEPTH = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  nnfs_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nnfs_pkg::PIX_W-1:0]    o_pixel_out,
    output logic [nnfs_pkg::DIM_W-1:0]    o_screen_x,
    output logic [nnfs_pkg::DIM_W-1:0]    o_screen_y,
    output logic [1:0]                    o_status
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [nnfs_pkg::CALC_W:0] Depth = (nnfs_pkg::CALC_W + 1)'(STORE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ADDR = 5'b00100,
        S_READ = 5'b01000,
        S_DONE = 5'b10000
    } t_back_state;

    t_back_state                   r_state;
    t_back_state                   n_state;

    logic [nnfs_pkg::PIX_W-1:0]    r_store [STORE_DEPTH];
    logic [nnfs_pkg::PIX_W-1:0]    r_rd_data;

    logic [nnfs_pkg::SRC_W-1:0]    r_in_w;
    logic [nnfs_pkg::SRC_W-1:0]    r_row;
    logic [nnfs_pkg::SRC_W-1:0]    r_col;
    logic [nnfs_pkg::CALC_W-1:0]   r_addr;
    logic [nnfs_pkg::DIM_W-1:0]    r_scr_x;
    logic [nnfs_pkg::DIM_W-1:0]    r_scr_y;
    nnfs_pkg::t_status             r_status;

    logic                          r_out_valid;
    logic [nnfs_pkg::PIX_W-1:0]    r_pixel_out;
    logic [nnfs_pkg::DIM_W-1:0]    r_out_sx;
    logic [nnfs_pkg::DIM_W-1:0]    r_out_sy;
    nnfs_pkg::t_status             r_out_status;

    logic                          is_write;
    logic                          is_fetch;
    logic                          wr_en;
    logic                          div_start;
    logic                          busy_row;
    logic                          busy_col;
    logic [nnfs_pkg::NUM_W-1:0]    quo_row;
    logic [nnfs_pkg::NUM_W-1:0]    quo_col;
    logic                          div_done;
    logic                          out_free;
    logic                          out_load;

    assign o_pop     = (r_state == S_IDLE) && i_job_valid;
    assign is_write  = o_pop && (i_job.op == nnfs_pkg::OP_WRITE);
    assign is_fetch  = o_pop && (i_job.op == nnfs_pkg::OP_FETCH);
    assign wr_en     = is_write &&
                       ({{(nnfs_pkg::CALC_W + 1 - nnfs_pkg::SADDR_W){1'b0}}, i_job.store_addr}
                        < Depth);
    assign div_start = is_fetch && (i_job.status == nnfs_pkg::ST_OK) && i_job.scaling;
    assign div_done  = !busy_row && !busy_col;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == S_DONE) && out_free;

    nnfs_div u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_job.num_row),
        .i_den   (i_job.den_row),
        .o_busy  (busy_row),
        .o_quo   (quo_row)
    );

    nnfs_div u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_job.num_col),
        .i_den   (i_job.den_col),
        .o_busy  (busy_col),
        .o_quo   (quo_col)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_fetch) begin
                    if (i_job.status != nnfs_pkg::ST_OK) begin
                        n_state = S_DONE;
                    end else if (i_job.scaling) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job datapath
    always_ff @(posedge i_clk) begin
        if (is_fetch) begin
            r_in_w   <= i_job.in_w;
            r_row    <= {1'b0, i_job.out_y};
            r_col    <= {1'b0, i_job.out_x};
            r_scr_x  <= i_job.screen_x;
            r_scr_y  <= i_job.screen_y;
            r_status <= i_job.status;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_row <= quo_row[nnfs_pkg::QUO_W-1:0];
            r_col <= quo_col[nnfs_pkg::QUO_W-1:0];
        end
        if (r_state == S_ADDR) begin
            r_addr <= nnfs_pkg::CALC_W'(r_row) * nnfs_pkg::CALC_W'(r_in_w)
                      + nnfs_pkg::CALC_W'(r_col);
        end
        if ((r_state == S_READ) && ({1'b0, r_addr} >= Depth)) begin
            r_status <= nnfs_pkg::ST_BEYOND;
        end
    end

    // Source store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[AW'(i_job.store_addr)] <= i_job.pixel_in;
        end
        r_rd_data <= r_store[AW'(r_addr)];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pixel_out  <= (r_status == nnfs_pkg::ST_OK) ? r_rd_data : '0;
            r_out_sx     <= r_scr_x;
            r_out_sy     <= r_scr_y;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_screen_x  = r_out_sx;
    assign o_screen_y  = r_out_sy;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    a_pixel_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != nnfs_pkg::ST_OK)) |-> (r_pixel_out == '0))
        else $error("pixel nonzero on error status");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (busy_row == busy_col))
        else $error("row and column dividers out of step");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && div_done) |->
        ((quo_row[nnfs_pkg::NUM_W-1:nnfs_pkg::QUO_W] == '0) &&
         (quo_col[nnfs_pkg::NUM_W-1:nnfs_pkg::QUO_W] == '0)))
        else $error("source index beyond source size");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result load lost");
`endif

endmodule

### hw/rtl/nearest_neighbor_frame_scaler_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// nearest_neighbor_frame_scaler_unit
// Nearest-neighbor RGB565 scaler with an on-chip source frame store.
// ============================================================================
// Usage:
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_we is
//   high (dest size, source size, window offset). Write only when idle.
//   Input channel (i_in_valid / o_in_stall): op 0 writes i_pixel_in to the
//   store at i_store_addr (no result); op 1 fetches output pixel
//   (i_out_x, i_out_y) of the window and gives exactly one result.
//   Output channel (o_out_valid / i_out_stall): pixel, screen coordinates
//   and status (ok, outside clip, source beyond store, invalid dimensions).
//   Flow: a write retires one per cycle while the back is idle. A fetch
//   passes address, read and done states to the result register; an error
//   fetch goes straight to done; a scaled fetch first runs the two 17-step
//   restoring dividers side by side. The back takes one fetch at a time.
//   A two-entry queue sits between front and back, so transfers keep being
//   taken while a result waits in the output register, until the queue fills.
//   i_out_stall holds the result; the back then stops, the queue fills and
//   o_in_stall rises. Reset restores the config defaults and empties the
//   queue; store contents are undefined until written.
// ============================================================================
module nearest_neighbor_frame_scaler_unit #(
    parameter int SCREEN_W    = 240,
    parameter int SCREEN_H    = 240,
    parameter int STORE_DEPTH = 32768
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [nnfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nnfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [nnfs_pkg::SADDR_W-1:0]     i_store_addr,
    input  logic [nnfs_pkg::PIX_W-1:0]       i_pixel_in,
    input  logic [nnfs_pkg::DIM_W-1:0]       i_out_x,
    input  logic [nnfs_pkg::DIM_W-1:0]       i_out_y,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [nnfs_pkg::PIX_W-1:0]       o_pixel_out,
    output logic [nnfs_pkg::DIM_W-1:0]       o_screen_x,
    output logic [nnfs_pkg::DIM_W-1:0]       o_screen_y,
    output logic [1:0]                       o_status
);

    nnfs_pkg::t_job push_job;
    nnfs_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;

    // Front: config registers, classification (clip, status, products)
    nnfs_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_op         (i_op),
        .i_store_addr (i_store_addr),
        .i_pixel_in   (i_pixel_in),
        .i_out_x      (i_out_x),
        .i_out_y      (i_out_y),
        .i_full       (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Writes and fetches share one queue, so store order is kept
    nnfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back: store, dividers, address, read and result register
    nnfs_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_status    (o_status)
    );

    assign o_in_stall = q_full;

endmodule
